// ----- hw/rtl/rgb_to_hsv_convert_assert.svh -----
// ----------------------------------------------------------------------------
// RGB to HSV assertion macros
// Concurrent check wrappers, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERT_ASSERT_SVH
`define RGB_TO_HSV_CONVERT_ASSERT_SVH

`ifndef SYNTHESIS
`define RTH_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rgb_to_hsv_convert: check failed");
`define RTH_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("rgb_to_hsv_convert: check failed");
`else
`define RTH_ASSERT(label, clk, rst, prop)
`define RTH_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- hw/rtl/rgbhsv_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV package
// Shared types for the conversion pipeline.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  typedef struct packed {
    logic black;
    logic full;
    logic gray;
  } hsv_flags_t;

endpackage

// ----- hw/rtl/rgbhsv_prep.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV front end
// Two stages: max/min and sector select, then hue numerator and divisors.
// ----------------------------------------------------------------------------
module rgbhsv_prep #(
  parameter int COLOR_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [COLOR_BITS-1:0]       red,
  input  logic [COLOR_BITS-1:0]       green,
  input  logic [COLOR_BITS-1:0]       blue,
  output logic                        out_valid,
  output logic [COLOR_BITS+2:0]       hue_rem,
  output logic [COLOR_BITS+2:0]       hue_div,
  output logic [COLOR_BITS-1:0]       sat_rem,
  output logic [COLOR_BITS-1:0]       sat_div,
  output logic [COLOR_BITS-1:0]       delta,
  output logic [COLOR_BITS-1:0]       vmax,
  output rgbhsv_pkg::hsv_flags_t      flags
);
  import rgbhsv_pkg::*;

  localparam int CW = COLOR_BITS;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  sector_t         sector_next;
  logic [CW-1:0]   max_next;
  logic [CW-1:0]   min_next;
  logic [CW:0]     diff_next;

  logic            s1_valid;
  sector_t         s1_sector;
  logic [CW-1:0]   s1_max;
  logic [CW-1:0]   s1_min;
  logic [CW:0]     s1_diff;

  logic [CW-1:0]   d;
  logic [CW+3:0]   offset;
  logic [CW+3:0]   num;
  logic [CW+3:0]   num_wrap;
  logic [CW+2:0]   six_d;

  always_comb begin
    if (red >= green && red >= blue) begin
      sector_next = SEC_RED;
    end else if (green >= blue) begin
      sector_next = SEC_GREEN;
    end else begin
      sector_next = SEC_BLUE;
    end
    if (red <= green && red <= blue) begin
      min_next = red;
    end else if (green <= blue) begin
      min_next = green;
    end else begin
      min_next = blue;
    end
    unique case (sector_next)
      SEC_RED: begin
        max_next  = red;
        diff_next = {1'b0, green} - {1'b0, blue};
      end
      SEC_GREEN: begin
        max_next  = green;
        diff_next = {1'b0, blue} - {1'b0, red};
      end
      default: begin
        max_next  = blue;
        diff_next = {1'b0, red} - {1'b0, green};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sector <= sector_next;
      s1_max    <= max_next;
      s1_min    <= min_next;
      s1_diff   <= diff_next;
    end
  end

  assign d     = s1_max - s1_min;
  assign six_d = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};

  always_comb begin
    unique case (s1_sector)
      SEC_RED:   offset = '0;
      SEC_GREEN: offset = {3'b000, d, 1'b0};
      default:   offset = {2'b00, d, 2'b00};
    endcase
    num = offset + {{3{s1_diff[CW]}}, s1_diff};
    if (num[CW+3]) begin
      num_wrap = num + {1'b0, six_d};
    end else begin
      num_wrap = num;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_rem     <= num_wrap[CW+2:0];
      hue_div     <= six_d;
      sat_rem     <= (d == s1_max) ? '0 : d;
      sat_div     <= s1_max;
      delta       <= d;
      vmax        <= s1_max;
      flags.black <= (s1_max == '0);
      flags.full  <= (d == s1_max);
      flags.gray  <= (d == '0);
    end
  end

endmodule

// ----- hw/rtl/rgbhsv_div.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV pipelined divider
// Restoring division, one quotient bit per stage, with leading delay stages
// to line up lanes of different quotient width. Remainder in must be below
// the divisor.
// ----------------------------------------------------------------------------
module rgbhsv_div #(
  parameter int DW    = 11,
  parameter int QW    = 16,
  parameter int STEPS = 16,
  parameter int SW    = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] rem_in,
  input  logic [DW-1:0] divisor,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quot,
  output logic [DW-1:0] rem_out,
  output logic [SW-1:0] side_out
);

  localparam int PAD = STEPS - QW;

  logic          v_q    [STEPS];
  logic [DW-1:0] rem_q  [STEPS];
  logic [DW-1:0] div_q  [STEPS];
  logic [QW-1:0] quot_q [STEPS];
  logic [SW-1:0] side_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] rem_prev;
    logic [DW-1:0] div_prev;
    logic [QW-1:0] quot_prev;
    logic [SW-1:0] side_prev;

    if (i == 0) begin : g_first
      assign v_in      = in_valid;
      assign rem_prev  = rem_in;
      assign div_prev  = divisor;
      assign quot_prev = '0;
      assign side_prev = side_in;
    end else begin : g_next
      assign v_in      = v_q[i-1];
      assign rem_prev  = rem_q[i-1];
      assign div_prev  = div_q[i-1];
      assign quot_prev = quot_q[i-1];
      assign side_prev = side_q[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (en) begin
        v_q[i] <= v_in;
      end
    end

    if (i < PAD) begin : g_delay
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i]  <= rem_prev;
          div_q[i]  <= div_prev;
          quot_q[i] <= quot_prev;
          side_q[i] <= side_prev;
        end
      end
    end else begin : g_step
      logic [DW:0] rem_sh;
      logic [DW:0] rem_sub;
      logic        take;

      assign rem_sh  = {rem_prev, 1'b0};
      assign rem_sub = rem_sh - {1'b0, div_prev};
      assign take    = (rem_sh >= {1'b0, div_prev});

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i]  <= take ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
          div_q[i]  <= div_prev;
          quot_q[i] <= {quot_prev[QW-2:0], take};
          side_q[i] <= side_prev;
        end
      end
    end
  end

  assign out_valid = v_q[STEPS-1];
  assign quot      = quot_q[STEPS-1];
  assign rem_out   = rem_q[STEPS-1];
  assign side_out  = side_q[STEPS-1];

endmodule

// ----- hw/rtl/rgb_to_hsv_convert.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Pixel stream conversion to hue, saturation and value, fully pipelined.
//
//   channel  direction  handshake              payload
//   pix      in         pix_valid / pix_stall  red, green, blue
//   hsv      out        hsv_valid / hsv_stall  hue, saturation, value
//
// One pixel per clock sustained unless a result stalls. Restoring dividers
// at one quotient bit per stage sit between prep and the output register.
// rst is synchronous and clears all valid bits; no clearing pass.
// A stalled result freezes the whole pipeline; pix_stall follows it in the
// same cycle.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_convert_assert.svh"

module rgb_to_hsv_convert #(
  parameter int COLOR_BITS = 8,
  parameter int HUE_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pix_valid,
  output logic                  pix_stall,
  input  logic [COLOR_BITS-1:0] red,
  input  logic [COLOR_BITS-1:0] green,
  input  logic [COLOR_BITS-1:0] blue,
  output logic                  hsv_valid,
  input  logic                  hsv_stall,
  output logic [HUE_BITS-1:0]   hue,
  output logic [COLOR_BITS-1:0] saturation,
  output logic [COLOR_BITS-1:0] value
);
  import rgbhsv_pkg::*;

  localparam int CW    = COLOR_BITS;
  localparam int FW    = $bits(hsv_flags_t);
  localparam int STEPS = (HUE_BITS > COLOR_BITS) ? HUE_BITS : COLOR_BITS;

  logic            en;
  logic            prep_valid;
  logic [CW+2:0]   hue_rem;
  logic [CW+2:0]   hue_div;
  logic [CW-1:0]   sat_rem;
  logic [CW-1:0]   sat_div;
  logic [CW-1:0]   delta;
  logic [CW-1:0]   vmax;
  hsv_flags_t      flags;

  logic            hue_valid;
  logic [HUE_BITS-1:0] hue_quot;
  logic [CW+2:0]   hue_rem_out;
  logic [CW-1:0]   vmax_out;

  logic            sat_valid;
  logic [CW-1:0]   sat_quot;
  logic [CW-1:0]   sat_rem_out;
  logic [FW+CW-1:0] sat_side;
  hsv_flags_t      flags_out;
  logic [CW-1:0]   delta_out;

  logic [CW-1:0]   sat_next;
  logic [HUE_BITS-1:0] hue_next;

  assign en        = !(hsv_valid && hsv_stall);
  assign pix_stall = !en;

  rgbhsv_prep #(
    .COLOR_BITS(COLOR_BITS)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (pix_valid),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .out_valid(prep_valid),
    .hue_rem  (hue_rem),
    .hue_div  (hue_div),
    .sat_rem  (sat_rem),
    .sat_div  (sat_div),
    .delta    (delta),
    .vmax     (vmax),
    .flags    (flags)
  );

  rgbhsv_div #(
    .DW   (CW + 3),
    .QW   (HUE_BITS),
    .STEPS(STEPS),
    .SW   (CW)
  ) u_hue_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (prep_valid),
    .rem_in   (hue_rem),
    .divisor  (hue_div),
    .side_in  (vmax),
    .out_valid(hue_valid),
    .quot     (hue_quot),
    .rem_out  (hue_rem_out),
    .side_out (vmax_out)
  );

  rgbhsv_div #(
    .DW   (CW),
    .QW   (CW),
    .STEPS(STEPS),
    .SW   (FW + CW)
  ) u_sat_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (prep_valid),
    .rem_in   (sat_rem),
    .divisor  (sat_div),
    .side_in  ({flags, delta}),
    .out_valid(sat_valid),
    .quot     (sat_quot),
    .rem_out  (sat_rem_out),
    .side_out (sat_side)
  );

  assign flags_out = hsv_flags_t'(sat_side[FW+CW-1:CW]);
  assign delta_out = sat_side[CW-1:0];

  always_comb begin
    if (flags_out.black) begin
      sat_next = '0;
    end else if (flags_out.full) begin
      sat_next = {CW{1'b1}};
    end else begin
      sat_next = sat_quot - {{(CW-1){1'b0}}, (sat_rem_out < delta_out)};
    end
    hue_next = flags_out.gray ? '0 : hue_quot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hsv_valid <= 1'b0;
    end else if (en) begin
      hsv_valid <= hue_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue        <= hue_next;
      saturation <= sat_next;
      value      <= vmax_out;
    end
  end

  `RTH_ASSERT(a_lanes_aligned, clk, rst, hue_valid == sat_valid)
  `RTH_ASSERT(a_gray_hue_zero, clk, rst, (hsv_valid && saturation == '0) |-> (hue == '0))
  `RTH_ASSERT(a_black_sat_zero, clk, rst, (hsv_valid && value == '0) |-> (saturation == '0))
  `RTH_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (!hsv_valid && !hue_valid))

endmodule

// ----- dv/rgb_to_hsv_convert_checker.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV converter checker
// Watches the pixel and result channels. Each pixel transfer is converted to
// its expected hue, saturation and value and queued. Each result transfer is
// compared field by field with the oldest queued entry. Mismatches and
// results with nothing queued are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert_checker #(
  parameter int COLOR_BITS = 8,
  parameter int HUE_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pix_valid,
  input  logic                  pix_stall,
  input  logic [COLOR_BITS-1:0] red,
  input  logic [COLOR_BITS-1:0] green,
  input  logic [COLOR_BITS-1:0] blue,
  input  logic                  hsv_valid,
  input  logic                  hsv_stall,
  input  logic [HUE_BITS-1:0]   hue,
  input  logic [COLOR_BITS-1:0] saturation,
  input  logic [COLOR_BITS-1:0] value,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint FULL_SCALE = (64'd1 << COLOR_BITS) - 1;
  localparam int     MAX_REPORTS = 10;

  typedef struct packed {
    logic [HUE_BITS-1:0]   hue;
    logic [COLOR_BITS-1:0] saturation;
    logic [COLOR_BITS-1:0] value;
  } hsv_result_t;

  hsv_result_t hsv_expected_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic hsv_result_t hsv_of_pixel(logic [COLOR_BITS-1:0] r,
                                               logic [COLOR_BITS-1:0] g,
                                               logic [COLOR_BITS-1:0] b);
    longint rv, gv, bv, vmax, vmin, d, num, hue_full, sat_full;
    hsv_result_t res;
    rv = r;
    gv = g;
    bv = b;
    vmax = rv;
    if (gv > vmax) vmax = gv;
    if (bv > vmax) vmax = bv;
    vmin = rv;
    if (gv < vmin) vmin = gv;
    if (bv < vmin) vmin = bv;
    d = vmax - vmin;
    sat_full = 0;
    hue_full = 0;
    if (vmax != 0) sat_full = (FULL_SCALE * d) / vmax;
    if (d != 0) begin
      if (rv == vmax) num = gv - bv;
      else if (gv == vmax) num = 2 * d + (bv - rv);
      else num = 4 * d + (rv - gv);
      if (num < 0) num += 6 * d;
      hue_full = (num << HUE_BITS) / (6 * d);
    end
    res.hue        = hue_full[HUE_BITS-1:0];
    res.saturation = sat_full[COLOR_BITS-1:0];
    res.value      = vmax[COLOR_BITS-1:0];
    return res;
  endfunction

  function automatic void note_failure(string what, hsv_result_t exp_r, hsv_result_t act_r);
    if (fail_count < MAX_REPORTS)
      $display("%0t hsv %s: expected hue %0d sat %0d val %0d, got hue %0d sat %0d val %0d",
               $realtime, what, exp_r.hue, exp_r.saturation, exp_r.value,
               act_r.hue, act_r.saturation, act_r.value);
    fail_count++;
  endfunction

  always @(posedge clk) begin
    hsv_result_t exp_r, act_r;
    if (!rst) begin
      if (hsv_valid && !hsv_stall) begin
        act_r.hue        = hue;
        act_r.saturation = saturation;
        act_r.value      = value;
        if (hsv_expected_q.size() == 0) begin
          note_failure("transfer with nothing expected", '0, act_r);
        end else begin
          exp_r = hsv_expected_q.pop_front();
          if (act_r.hue !== exp_r.hue || act_r.saturation !== exp_r.saturation ||
              act_r.value !== exp_r.value)
            note_failure("mismatch", exp_r, act_r);
        end
      end
      if (pix_valid && !pix_stall)
        hsv_expected_q.push_back(hsv_of_pixel(red, green, blue));
      pending = hsv_expected_q.size();
    end
  end

endmodule

// ----- dv/rgb_to_hsv_convert_test.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Drives directed corner pixels (black, white, primaries, grays, ties between
// components, hue wrap) and then random pixels under three idle patterns on
// the pixel and result channels. A separate checker predicts and compares;
// this top only makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLOR_BITS   = 8;
  localparam int HUE_BITS     = 16;
  localparam int RANDOM_ITEMS = 1900;
  localparam int DRAIN_CYCLES = 3 * (3 + HUE_BITS);
  localparam int CYCLE_LIMIT  = 400000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  pix_valid = 1'b0;
  logic                  pix_stall;
  logic [COLOR_BITS-1:0] red = '0;
  logic [COLOR_BITS-1:0] green = '0;
  logic [COLOR_BITS-1:0] blue = '0;
  logic                  hsv_valid;
  logic                  hsv_stall = 1'b0;
  logic [HUE_BITS-1:0]   hue;
  logic [COLOR_BITS-1:0] saturation;
  logic [COLOR_BITS-1:0] value;

  int fail_count;
  int pending;
  int pix_idle_pct = 29;
  int hsv_stall_pct = 72;
  int cycles = 0;

  rgb_to_hsv_convert #(
    .COLOR_BITS(COLOR_BITS),
    .HUE_BITS  (HUE_BITS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .hsv_valid (hsv_valid),
    .hsv_stall (hsv_stall),
    .hue       (hue),
    .saturation(saturation),
    .value     (value)
  );

  rgb_to_hsv_convert_checker #(
    .COLOR_BITS(COLOR_BITS),
    .HUE_BITS  (HUE_BITS)
  ) u_hsv_check (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .hsv_valid (hsv_valid),
    .hsv_stall (hsv_stall),
    .hue       (hue),
    .saturation(saturation),
    .value     (value),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("rgb_to_hsv_convert verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst) hsv_stall <= ($urandom_range(99) < hsv_stall_pct);
  end

  task automatic send_pixel(logic [COLOR_BITS-1:0] r, logic [COLOR_BITS-1:0] g,
                            logic [COLOR_BITS-1:0] b);
    while ($urandom_range(99) < pix_idle_pct) begin
      pix_valid <= 1'b0;
      @(negedge clk);
    end
    pix_valid <= 1'b1;
    red       <= r;
    green     <= g;
    blue      <= b;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [COLOR_BITS-1:0] r, g, b, base;
    int mode, spread;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd254, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd254, 8'd255);
    send_pixel(8'd170, 8'd85, 8'd255);
    send_pixel(8'd85, 8'd170, 8'd0);
    send_pixel(8'd200, 8'd100, 8'd150);
    send_pixel(8'd10, 8'd20, 8'd30);

    pix_valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        pix_idle_pct  = 72;
        hsv_stall_pct = 29;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        pix_idle_pct  = 0;
        hsv_stall_pct = 0;
      end
      mode = $urandom_range(9);
      r = COLOR_BITS'($urandom);
      g = COLOR_BITS'($urandom);
      b = COLOR_BITS'($urandom);
      case (mode)
        5: begin
          g = r;
          b = r;
        end
        6: begin
          r = COLOR_BITS'(($urandom_range(1)) ? 8'd255 - $urandom_range(1) : $urandom_range(1));
          g = COLOR_BITS'(($urandom_range(1)) ? 8'd255 - $urandom_range(1) : $urandom_range(1));
          b = COLOR_BITS'(($urandom_range(1)) ? 8'd255 - $urandom_range(1) : $urandom_range(1));
        end
        7: begin
          base   = COLOR_BITS'($urandom);
          spread = $urandom_range(3);
          r = (int'(base) + spread > 255) ? 8'd255 : COLOR_BITS'(int'(base) + spread);
          g = base;
          b = (int'(base) < spread) ? 8'd0 : COLOR_BITS'(int'(base) - spread);
        end
        8: begin
          case ($urandom_range(2))
            0: g = r;
            1: b = g;
            default: b = r;
          endcase
        end
        default: begin
        end
      endcase
      send_pixel(r, g, b);
    end
    pix_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("rgb_to_hsv_convert verification clean");
    end else begin
      $display("rgb_to_hsv_convert verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/rgbhsv_pkg.sv
hw/rtl/rgbhsv_prep.sv
hw/rtl/rgbhsv_div.sv
hw/rtl/rgb_to_hsv_convert.sv
dv/rgb_to_hsv_convert_checker.sv
dv/rgb_to_hsv_convert_test.sv
